/* hw/rtl/mountain_car_physics_step_top_macros.svh */
// Assertion macros used by the mountain car physics core RTL.
`ifndef MOUNTAIN_CAR_PHYSICS_STEP_TOP_MACROS_SVH
`define MOUNTAIN_CAR_PHYSICS_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mcp assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define MCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mcp assertion failed (next cycle)");

`endif

/* hw/rtl/mcp_pkg.sv */
// Shared types and constants for the mountain car physics step block.
`default_nettype none
package mcp_pkg;

	// Input command carried in tuser
	typedef enum logic {
		CMD_STEP    = 1'b0,
		CMD_RESTART = 1'b1
	} cmd_t;

	// Episode status reported with each result
	typedef enum logic [1:0] {
		END_RUNNING = 2'd0,
		END_GOAL    = 2'd1,
		END_LIMIT   = 2'd2
	} end_code_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_POWER_GAIN    = 3'd0,
		REG_SPEED_LIMIT   = 3'd1,
		REG_LEFT_BOUND    = 3'd2,
		REG_RIGHT_BOUND   = 3'd3,
		REG_GOAL_PLACE    = 3'd4,
		REG_GOAL_SPEED    = 3'd5,
		REG_EPISODE_LIMIT = 3'd6
	} reg_index_t;

	// Register reset values
	localparam logic        [20:0] POWER_GAIN_RST    = 21'd1573;
	localparam logic        [20:0] SPEED_LIMIT_RST   = 21'd73400;
	localparam logic signed [23:0] LEFT_BOUND_RST    = -24'sd1258291;
	localparam logic        [22:0] RIGHT_BOUND_RST   = 23'd629146;
	localparam logic signed [23:0] GOAL_PLACE_RST    = 24'sd524288;
	localparam logic signed [21:0] GOAL_SPEED_RST    = 22'sd0;
	localparam logic        [15:0] EPISODE_LIMIT_RST = 16'd999;

	// Configuration register file contents
	typedef struct packed {
		logic        [20:0] power_gain;
		logic        [20:0] speed_limit;
		logic signed [23:0] left_bound;
		logic        [22:0] right_bound;
		logic signed [23:0] goal_place;
		logic signed [21:0] goal_speed;
		logic        [15:0] episode_limit;
	} cfg_t;

	// Car state, which is also the result of the last transaction
	typedef struct packed {
		logic signed [23:0] car_position;
		logic signed [21:0] car_velocity;
		logic        [15:0] steps_taken;
		end_code_t          episode_end;
	} car_state_t;

endpackage
`default_nettype wire

/* hw/rtl/mcp_cfg.sv */
// Configuration register file for the mountain car physics step.
`default_nettype none
module mcp_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [23:0]  cfg_data,
	output mcp_pkg::cfg_t     cfg
);
	import mcp_pkg::*;

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_gain    <= POWER_GAIN_RST;
			cfg_q.speed_limit   <= SPEED_LIMIT_RST;
			cfg_q.left_bound    <= LEFT_BOUND_RST;
			cfg_q.right_bound   <= RIGHT_BOUND_RST;
			cfg_q.goal_place    <= GOAL_PLACE_RST;
			cfg_q.goal_speed    <= GOAL_SPEED_RST;
			cfg_q.episode_limit <= EPISODE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_POWER_GAIN:    cfg_q.power_gain    <= cfg_data[20:0];
				REG_SPEED_LIMIT:   cfg_q.speed_limit   <= cfg_data[20:0];
				REG_LEFT_BOUND:    cfg_q.left_bound    <= signed'(cfg_data[23:0]);
				REG_RIGHT_BOUND:   cfg_q.right_bound   <= cfg_data[22:0];
				REG_GOAL_PLACE:    cfg_q.goal_place    <= signed'(cfg_data[23:0]);
				REG_GOAL_SPEED:    cfg_q.goal_speed    <= signed'(cfg_data[21:0]);
				REG_EPISODE_LIMIT: cfg_q.episode_limit <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* hw/rtl/mcp_in_stage.sv */
// Input register stage: captures a transaction and forms the force term.
`default_nettype none
module mcp_in_stage #(
	parameter int FRACTION_BITS = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic                          drain,
	input  wire mcp_pkg::cmd_t                 command,
	input  wire logic signed [23:0]            force_req,
	input  wire logic signed [20:0]            start_position,
	input  wire logic        [20:0]            power_gain,
	output logic                               valid_s1,
	output mcp_pkg::cmd_t                      cmd_s1,
	output logic signed [20:0]                 start_s1,
	output logic signed [46-FRACTION_BITS:0]   fterm_s1
);
	import mcp_pkg::*;

	localparam int FT_W = 47 - FRACTION_BITS;
	localparam logic [45:0] HALF = 46'(1) << (FRACTION_BITS - 1);
	localparam logic [23:0] ONE_CLAMP =
		(FRACTION_BITS >= 23) ? 24'h80_0000 : (24'(1) << FRACTION_BITS);

	logic                   force_neg;
	logic [23:0]            force_mag;
	logic [23:0]            force_clamped;
	logic [45:0]            gain_prod;
	logic [45:0]            gain_rnd;
	logic [FT_W-1:0]        fterm_abs;
	logic signed [FT_W-1:0] fterm;

	// Clamp |force| to one, then force * gain rounded half away from zero
	always_comb begin
		force_neg     = force_req[23];
		force_mag     = force_neg ? 24'(-force_req) : 24'(force_req);
		force_clamped = (force_mag > ONE_CLAMP) ? ONE_CLAMP : force_mag;
		gain_prod     = 46'(force_clamped) * 46'(power_gain);
		gain_rnd      = (gain_prod + HALF) >> FRACTION_BITS;
		fterm_abs     = gain_rnd[FT_W-1:0];
		fterm         = force_neg ? -signed'(fterm_abs) : signed'(fterm_abs);
	end

	// Stage valid: filled on accept, emptied when the core takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1   <= command;
			start_s1 <= start_position;
			fterm_s1 <= fterm;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/mcp_core.sv */
// Physics update: slope lookup, velocity and position clamps, episode control.
`default_nettype none
`include "mountain_car_physics_step_top_macros.svh"
module mcp_core #(
	parameter int FRACTION_BITS     = 20,
	parameter int SLOPE_TABLE_DEPTH = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire mcp_pkg::cmd_t                 cmd,
	input  wire logic signed [20:0]            start_position,
	input  wire logic signed [46-FRACTION_BITS:0] fterm,
	input  wire mcp_pkg::cfg_t                 cfg,
	output mcp_pkg::car_state_t                state
);
	import mcp_pkg::*;

	localparam int FT_W      = 47 - FRACTION_BITS;
	localparam int VW        = ((FT_W > 22) ? FT_W : 22) + 2;
	localparam int SLOPE_MAX = ((1 << FRACTION_BITS) + 200) / 400;
	localparam int SLOPE_W   = $clog2(SLOPE_MAX + 1) + 1;
	localparam int IDX_W     = $clog2(SLOPE_TABLE_DEPTH);
	localparam int PW        = FRACTION_BITS + 32;
	// 3 * round(2^32 / (2*pi)): position to phase of 3*position in Q32 turns
	localparam logic [30:0] PHASE_MUL   = 31'd2050695828;
	localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
	localparam logic [63:0] Q30_ONE     = 64'h4000_0000;
	localparam logic [63:0] SLOPE_DEN   = 64'd400 << 30;
	localparam logic [63:0] TABLE_DEPTH = 64'(SLOPE_TABLE_DEPTH);
	// Taylor term divisors (2k-1)*(2k) for k = 1..8
	localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd2, 64'd12, 64'd30, 64'd56,
		64'd90, 64'd132, 64'd182, 64'd240};

	// One table entry: 0.0025 * cos(2*pi*i/depth), Taylor series in Q30
	function automatic logic signed [31:0] slope_entry(input int unsigned idx);
		logic [63:0]        u;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        c;
		logic [63:0]        mag;
		logic signed [63:0] sum;
		logic               neg;
		u   = (64'(idx) << 32) / TABLE_DEPTH;
		neg = 1'b0;
		if (u > 64'h8000_0000) begin
			u = 64'h1_0000_0000 - u;
		end
		if (u > Q30_ONE) begin
			neg = 1'b1;
			u   = 64'h8000_0000 - u;
		end
		x    = (u * TWO_PI_Q30) >> 32;
		x2   = (x * x) >> 30;
		sum  = signed'(Q30_ONE);
		term = Q30_ONE;
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k];
			if (k % 2 == 1) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		c   = (sum < 0) ? 64'd0 : unsigned'(sum);
		mag = ((c << FRACTION_BITS) + (SLOPE_DEN >> 1)) / SLOPE_DEN;
		return neg ? -signed'(32'(mag)) : signed'(32'(mag));
	endfunction

	localparam logic signed [SLOPE_W-1:0] SLOPE_RST = SLOPE_W'(slope_entry(0));

	// Slope ROM
	logic signed [SLOPE_W-1:0] slope_rom [SLOPE_TABLE_DEPTH];
	for (genvar gi = 0; gi < SLOPE_TABLE_DEPTH; gi++) begin : g_rom
		localparam logic signed [SLOPE_W-1:0] ENTRY = SLOPE_W'(slope_entry(gi));
		assign slope_rom[gi] = ENTRY;
	end

	car_state_t                state_q;
	logic signed [SLOPE_W-1:0] slope_q;

	logic signed [VW-1:0]  v_raw;
	logic signed [VW-1:0]  v_lim;
	logic signed [21:0]    v_cl;
	logic signed [21:0]    v_fin;
	logic signed [25:0]    p_raw;
	logic signed [25:0]    p_lb;
	logic signed [25:0]    p_rb;
	logic signed [25:0]    p_cl;
	logic signed [23:0]    p_fin;
	logic        [15:0]    steps_inc;
	logic signed [23:0]    start_ext;
	logic                  goal_hit;
	logic                  limit_hit;
	end_code_t             end_next;
	car_state_t            state_next;
	logic        [PW-1:0]  phase_prod;
	logic        [31:0]    phase;
	logic        [47:0]    idx_prod;
	logic        [IDX_W-1:0] slope_idx;

	// Velocity update and clamp to the speed limit
	always_comb begin
		v_raw = VW'(state_q.car_velocity) + VW'(fterm) - VW'(slope_q);
		v_lim = signed'(VW'(cfg.speed_limit));
		if (v_raw > v_lim) begin
			v_cl = 22'(v_lim);
		end else if (v_raw < -v_lim) begin
			v_cl = 22'(-v_lim);
		end else begin
			v_cl = 22'(v_raw);
		end
	end

	// Position update, left clamp first then right, left wall stop
	always_comb begin
		p_raw = 26'(state_q.car_position) + 26'(v_cl);
		p_lb  = 26'(cfg.left_bound);
		p_rb  = signed'({3'b000, cfg.right_bound});
		p_cl  = p_raw;
		if (p_cl < p_lb) begin
			p_cl = p_lb;
		end
		if (p_cl > p_rb) begin
			p_cl = p_rb;
		end
		p_fin = 24'(p_cl);
		v_fin = ((p_cl == p_lb) && (v_cl < 0)) ? 22'sd0 : v_cl;
	end

	// Step count, goal and limit checks, restart selection
	always_comb begin
		steps_inc = state_q.steps_taken + 16'd1;
		start_ext = 24'(start_position);
		goal_hit  = (p_fin >= cfg.goal_place) && (v_fin >= cfg.goal_speed);
		limit_hit = (steps_inc >= cfg.episode_limit);
		priority if (goal_hit) begin
			end_next = END_GOAL;
		end else if (limit_hit) begin
			end_next = END_LIMIT;
		end else begin
			end_next = END_RUNNING;
		end

		priority if (cmd == CMD_RESTART) begin
			state_next.car_position = start_ext;
			state_next.car_velocity = '0;
			state_next.steps_taken  = '0;
			state_next.episode_end  = END_RUNNING;
		end else if (end_next != END_RUNNING) begin
			state_next.car_position = start_ext;
			state_next.car_velocity = '0;
			state_next.steps_taken  = '0;
			state_next.episode_end  = end_next;
		end else begin
			state_next.car_position = p_fin;
			state_next.car_velocity = v_fin;
			state_next.steps_taken  = steps_inc;
			state_next.episode_end  = END_RUNNING;
		end
	end

	// Table index of the next position: phase of 3*position scaled to depth
	always_comb begin
		phase_prod = PW'(state_next.car_position) * PW'(PHASE_MUL);
		phase      = phase_prod[PW-1:FRACTION_BITS];
		idx_prod   = 48'(phase) * 48'(SLOPE_TABLE_DEPTH);
		slope_idx  = idx_prod[32 +: IDX_W];
	end

	// State and slope registers; the slope always matches the held position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.car_position <= '0;
			state_q.car_velocity <= '0;
			state_q.steps_taken  <= '0;
			state_q.episode_end  <= END_RUNNING;
			slope_q              <= SLOPE_RST;
		end else if (adv) begin
			state_q <= state_next;
			slope_q <= slope_rom[slope_idx];
		end
	end

	assign state = state_q;

	// An episode end always leaves a stopped car with a cleared step count
	`MCP_ASSERT_IMPL(a_end_clears, clk, arst_n, state_q.episode_end != END_RUNNING, state_q.steps_taken == '0 && state_q.car_velocity == '0)
	// A new-episode command loads the start position
	`MCP_ASSERT_NEXT(a_restart_loads, clk, arst_n, adv && cmd == CMD_RESTART, state_q.car_position == $past(start_ext) && state_q.steps_taken == '0 && state_q.episode_end == END_RUNNING)
	// A running step advances the counter by one
	`MCP_ASSERT_NEXT(a_step_counts, clk, arst_n, adv && cmd == CMD_STEP && end_next == END_RUNNING, state_q.steps_taken == $past(steps_inc))
	// State and slope hold when no transaction is processed
	`MCP_ASSERT_NEXT(a_hold, clk, arst_n, !adv, $stable(state_q) && $stable(slope_q))

endmodule
`default_nettype wire

/* hw/rtl/mountain_car_physics_step_top.sv */
// Top level of the mountain car physics step block.
// Result tvalid rises when an accepted transaction has passed the input register and then the
// state/result register. Throughput: one transaction per cycle unless m_axis_tready stalls.
// The next item's slope is read from the ROM at the edge that stores the new position.
// Reset: arst_n clears position, velocity, step count and the valid flags, and
// loads the registers with their defaults; no clearing pass is needed.
`default_nettype none
module mountain_car_physics_step_top #(
	parameter int FRACTION_BITS     = 20,
	parameter int SLOPE_TABLE_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // force_req[23:0], start_position[44:24], zero pad
	input  wire logic [0:0]  s_axis_tuser,  // command[0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // car_position[23:0], car_velocity[45:24],
	                                        // steps_taken[61:46], episode_end[63:62]
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);
	import mcp_pkg::*;

	cfg_t                          cfg;
	car_state_t                    state;
	logic                          valid_s1;
	cmd_t                          cmd_s1;
	logic signed [20:0]            start_s1;
	logic signed [46-FRACTION_BITS:0] fterm_s1;
	logic                          accept;
	logic                          adv;
	logic                          out_valid_q;

	// Handshake: the stage drains into the result register when it is free
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	mcp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mcp_in_stage #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_in_stage (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (accept),
		.drain          (adv),
		.command        (cmd_t'(s_axis_tuser[0])),
		.force_req      (signed'(s_axis_tdata[23:0])),
		.start_position (signed'(s_axis_tdata[44:24])),
		.power_gain     (cfg.power_gain),
		.valid_s1       (valid_s1),
		.cmd_s1         (cmd_s1),
		.start_s1       (start_s1),
		.fterm_s1       (fterm_s1)
	);

	mcp_core #(
		.FRACTION_BITS     (FRACTION_BITS),
		.SLOPE_TABLE_DEPTH (SLOPE_TABLE_DEPTH)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.cmd            (cmd_s1),
		.start_position (start_s1),
		.fterm          (fterm_s1),
		.cfg            (cfg),
		.state          (state)
	);

	// Result valid: the state register doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {state.episode_end, state.steps_taken,
		state.car_velocity, state.car_position};

endmodule
`default_nettype wire

/* tb/mountain_car_physics_step_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the mountain car physics step block, with its own physics predictor.
module mountain_car_physics_step_top_tb;
	import mcp_pkg::*;

	localparam logic [2:0] REG_UNUSED     = 3'd7;   // no register behind this index
	localparam int         CYCLE_LIMIT    = 400000;
	localparam int         HOLD_AT_RESULT = 300;
	localparam int         HOLD_CYCLES    = 250;

	typedef enum {RX_FREE, RX_COIN, RX_QUARTER, RX_ALTERNATE} rx_mode_t;

	// Physics predictor plus the queue of car states still owed by the block
	class car_physics_scoreboard;
		localparam int              FRAC           = 20;
		localparam int              ROM_DEPTH      = 1024;
		localparam longint          ONE            = 64'sd1 << FRAC;
		localparam longint unsigned TWO_PI_Q30     = 64'd6746518852;
		localparam longint unsigned INV_TWO_PI_Q32 = 64'd683565276;
		localparam longint unsigned Q30_ONE        = 64'd1 << 30;

		int          slope_rom[ROM_DEPTH];
		cfg_t        cfg;
		longint      position;
		longint      velocity;
		logic [15:0] step_count;
		car_state_t  expected_states[$];
		int          mismatches;

		function new();
			longint unsigned u;
			longint unsigned c;
			longint unsigned den;
			longint unsigned mag;
			bit              neg;
			// cosine ROM, folded into the first quadrant
			for (int i = 0; i < ROM_DEPTH; i++) begin
				u = (64'(i) << 32) / ROM_DEPTH;
				neg = 1'b0;
				if (u > (64'd1 << 31))
					u = (64'd1 << 32) - u;
				if (u > (64'd1 << 30)) begin
					neg = 1'b1;
					u = (64'd1 << 31) - u;
				end
				c = cos_quarter(u);
				den = 64'd400 << 30;
				mag = ((c << FRAC) + den / 2) / den;
				slope_rom[i] = neg ? -int'(mag) : int'(mag);
			end
			position = 0;
			velocity = 0;
			step_count = '0;
			mismatches = 0;
			cfg.power_gain = POWER_GAIN_RST;
			cfg.speed_limit = SPEED_LIMIT_RST;
			cfg.left_bound = LEFT_BOUND_RST;
			cfg.right_bound = RIGHT_BOUND_RST;
			cfg.goal_place = GOAL_PLACE_RST;
			cfg.goal_speed = GOAL_SPEED_RST;
			cfg.episode_limit = EPISODE_LIMIT_RST;
		endfunction

		// Q30 Taylor cosine of a quarter-turn phase (Q32 turns)
		function longint unsigned cos_quarter(longint unsigned u);
			longint unsigned x;
			longint unsigned x2;
			longint unsigned term;
			longint unsigned div;
			longint          sum;
			x = (u * TWO_PI_Q30) >> 32;
			x2 = (x * x) >> 30;
			sum = Q30_ONE;
			term = Q30_ONE;
			for (int k = 1; k <= 8; k++) begin
				div = (2 * k - 1) * (2 * k);
				term = ((term * x2) >> 30) / div;
				if (k % 2 == 1)
					sum = sum - term;
				else
					sum = sum + term;
			end
			return (sum < 0) ? 64'd0 : sum;
		endfunction

		// phase of 3*position in turns, scaled to a ROM address
		function int slope_index(longint p);
			longint unsigned t;
			t = 3 * p;
			t = (t * INV_TWO_PI_Q32) >> FRAC;
			t = t & 64'hFFFF_FFFF;
			return int'((t * ROM_DEPTH) >> 32);
		endfunction

		// force * gain in Q20, nearest, ties away from zero
		function longint force_term(longint f, longint unsigned gain);
			longint unsigned mag;
			longint unsigned r;
			mag = (f < 0) ? -f : f;
			r = (mag * gain + (64'd1 << (FRAC - 1))) >> FRAC;
			return (f < 0) ? -longint'(r) : longint'(r);
		endfunction

		function car_state_t advance_car(cmd_t cmd, logic [23:0] force_val,
			logic [20:0] start_val);
			car_state_t res;
			end_code_t  outcome;
			longint     start;
			longint     f;
			longint     lim;
			longint     lb;
			longint     rb;
			longint     v;
			longint     p;
			start = $signed(start_val);
			outcome = END_RUNNING;
			if (cmd == CMD_RESTART) begin
				position = start;
				velocity = 0;
				step_count = '0;
			end else begin
				f = $signed(force_val);
				if (f > ONE)
					f = ONE;
				if (f < -ONE)
					f = -ONE;
				lim = cfg.speed_limit;
				lb = $signed(cfg.left_bound);
				rb = cfg.right_bound;
				v = velocity + force_term(f, cfg.power_gain) - slope_rom[slope_index(position)];
				if (v > lim)
					v = lim;
				if (v < -lim)
					v = -lim;
				// left clamp first, so crossed bounds end at the right bound
				p = position + v;
				if (p < lb)
					p = lb;
				if (p > rb)
					p = rb;
				if (p == lb && v < 0)
					v = 0;
				step_count = step_count + 16'd1;
				position = p;
				velocity = v;
				if (p >= longint'($signed(cfg.goal_place)) && v >= longint'($signed(cfg.goal_speed)))
					outcome = END_GOAL;
				else if (step_count >= cfg.episode_limit)
					outcome = END_LIMIT;
				if (outcome != END_RUNNING) begin
					position = start;
					velocity = 0;
					step_count = '0;
				end
			end
			res.car_position = position[23:0];
			res.car_velocity = velocity[21:0];
			res.steps_taken = step_count;
			res.episode_end = outcome;
			return res;
		endfunction

		function void note_input(cmd_t cmd, logic [23:0] force_val, logic [20:0] start_val);
			expected_states.push_back(advance_car(cmd, force_val, start_val));
		endfunction

		function void write_reg(logic [2:0] idx, logic [23:0] val);
			case (idx)
				REG_POWER_GAIN:    cfg.power_gain = val[20:0];
				REG_SPEED_LIMIT:   cfg.speed_limit = val[20:0];
				REG_LEFT_BOUND:    cfg.left_bound = val[23:0];
				REG_RIGHT_BOUND:   cfg.right_bound = val[22:0];
				REG_GOAL_PLACE:    cfg.goal_place = val[23:0];
				REG_GOAL_SPEED:    cfg.goal_speed = val[21:0];
				REG_EPISODE_LIMIT: cfg.episode_limit = val[15:0];
				default: ;
			endcase
		endfunction

		function void check_result(logic [63:0] data);
			car_state_t         want;
			logic signed [23:0] pos;
			logic signed [21:0] vel;
			logic        [15:0] steps;
			logic        [1:0]  code;
			if (expected_states.size() == 0) begin
				$error("result transaction with nothing pending: %h", data);
				mismatches++;
				return;
			end
			want = expected_states.pop_front();
			pos = data[23:0];
			vel = data[45:24];
			steps = data[61:46];
			code = data[63:62];
			if (pos !== want.car_position) begin
				$error("car_position: expected %0d, actual %0d", want.car_position, pos);
				mismatches++;
			end
			if (vel !== want.car_velocity) begin
				$error("car_velocity: expected %0d, actual %0d", want.car_velocity, vel);
				mismatches++;
			end
			if (steps !== want.steps_taken) begin
				$error("steps_taken: expected %0d, actual %0d", want.steps_taken, steps);
				mismatches++;
			end
			if (code !== want.episode_end) begin
				$error("episode_end: expected %0d, actual %0d", want.episode_end, code);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;    // force_req[23:0], start_position[44:24], zero pad
	logic [0:0]  s_axis_tuser = '0;    // command[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;         // car_position[23:0], car_velocity[45:24],
	                                   // steps_taken[61:46], episode_end[63:62]
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	int          cycle_count = 0;

	car_physics_scoreboard car_sb;

	mountain_car_physics_step_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: check each transaction, then pick the next tready
	initial begin
		int       results = 0;
		int       hold_left = 0;
		int       rx_cycle = 0;
		bit       hold_done = 1'b0;
		rx_mode_t rx_mode = RX_FREE;
		logic     ready_next;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				car_sb.check_result(m_axis_tdata);
				results++;
			end
			if (rx_cycle % 64 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_cycle++;
			// one long hold-off so the pipeline backs up into the input
			if (!hold_done && results >= HOLD_AT_RESULT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE:     ready_next = 1'b1;
					RX_COIN:     ready_next = $urandom_range(0, 1);
					RX_QUARTER:  ready_next = (rx_cycle % 4 == 0);
					default:     ready_next = rx_cycle[0];
				endcase
			end
			m_axis_tready <= ready_next;
		end
	end

	// One input transaction; tvalid stays high afterwards
	task automatic send_item(input cmd_t cmd, input logic [23:0] force_val,
		input logic [20:0] start_val);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, start_val, force_val};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		car_sb.note_input(cmd, force_val, start_val);
	endtask

	// Mostly a bang-bang policy on the predicted velocity, to reach the goal; rest is noise
	task automatic run_random(input int count);
		int          burst_left;
		int          r;
		int          mag;
		cmd_t        cmd;
		logic [23:0] force_val;
		logic [20:0] start_val;
		burst_left = $urandom_range(1, 24);
		repeat (count) begin
			if (burst_left == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
			end
			r = $urandom_range(0, 99);
			cmd = (r < 3) ? CMD_RESTART : CMD_STEP;
			if ($urandom_range(0, 6) == 0)
				start_val = 21'($urandom);
			else
				start_val = 21'(int'($urandom_range(0, 209716)) - 629146);
			if (r < 3 || r >= 90) begin
				force_val = 24'($urandom);
			end else if (r < 80) begin
				mag = $urandom_range(600000, 1400000);
				if (car_sb.velocity < 0 || (car_sb.velocity == 0 && $urandom_range(0, 1)))
					force_val = 24'(-mag);
				else
					force_val = 24'(mag);
			end else begin
				force_val = 24'(int'($urandom_range(0, 2097152)) - 1048576);
			end
			send_item(cmd, force_val, start_val);
			burst_left--;
		end
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic program_register(input logic [2:0] idx, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		car_sb.write_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Sender pauses until every owed result is back, then lets the pipeline settle
	task automatic wait_for_results();
		while (car_sb.expected_states.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		car_sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: steps from the reset state, force extremes, start extremes
		send_item(CMD_STEP, 24'd0, 21'd0);
		send_item(CMD_STEP, 24'h7FFFFF, 21'(-500000));
		send_item(CMD_STEP, 24'h800000, 21'(-500000));
		send_item(CMD_RESTART, 24'd0, 21'(-629146));
		send_item(CMD_STEP, 24'd1048576, 21'(-629146));
		send_item(CMD_STEP, 24'(-1048576), 21'(-629146));
		send_item(CMD_STEP, 24'd1048577, 21'(-419430));
		send_item(CMD_STEP, 24'(-1048577), 21'(-419430));
		send_item(CMD_RESTART, 24'h555555, 21'(-419430));
		send_item(CMD_STEP, 24'hAAAAAA, 21'h0AAAAA);
		send_item(CMD_RESTART, 24'hFFFFFF, 21'h100000);
		send_item(CMD_STEP, 24'd0, 21'h100000);
		send_item(CMD_RESTART, 24'd0, 21'h0FFFFF);
		send_item(CMD_STEP, 24'd0, 21'h155555);
		send_item(CMD_STEP, 24'd1048576, 21'h0AAAAA);
		send_item(CMD_RESTART, 24'd0, 21'h000000);
		send_item(CMD_STEP, 24'h000001, 21'h1FFFFF);
		send_item(CMD_STEP, 24'hFFFFFF, 21'(-500000));
		run_random(600);

		// maximum gain and speed, goal on any velocity
		wait_for_results();
		program_register(REG_POWER_GAIN, 24'd1048576);
		program_register(REG_SPEED_LIMIT, 24'd1048576);
		program_register(REG_GOAL_SPEED, 24'(-1048576));
		program_register(REG_EPISODE_LIMIT, 24'd65535);
		run_random(150);

		// no gain, no speed, zero episode limit
		wait_for_results();
		program_register(REG_POWER_GAIN, 24'd0);
		program_register(REG_SPEED_LIMIT, 24'd0);
		program_register(REG_EPISODE_LIMIT, 24'd0);
		run_random(60);

		// widest bounds, goal out of reach, short episodes
		wait_for_results();
		program_register(REG_POWER_GAIN, 24'd4000);
		program_register(REG_SPEED_LIMIT, 24'd73400);
		program_register(REG_LEFT_BOUND, 24'(-8388608));
		program_register(REG_RIGHT_BOUND, 24'd8388607);
		program_register(REG_GOAL_PLACE, 24'd8388607);
		program_register(REG_GOAL_SPEED, 24'd1048576);
		program_register(REG_EPISODE_LIMIT, 24'd50);
		run_random(200);

		// crossed bounds, then both bounds at zero
		wait_for_results();
		program_register(REG_POWER_GAIN, 24'(POWER_GAIN_RST));
		program_register(REG_LEFT_BOUND, 24'd100000);
		program_register(REG_RIGHT_BOUND, 24'd50000);
		program_register(REG_GOAL_PLACE, 24'(-8388608));
		program_register(REG_GOAL_SPEED, 24'd0);
		program_register(REG_EPISODE_LIMIT, 24'd999);
		run_random(80);
		wait_for_results();
		program_register(REG_LEFT_BOUND, 24'd0);
		program_register(REG_RIGHT_BOUND, 24'd0);
		run_random(40);

		// limit lowered below the running step count; unmapped write ignored
		wait_for_results();
		program_register(REG_LEFT_BOUND, LEFT_BOUND_RST);
		program_register(REG_RIGHT_BOUND, 24'(RIGHT_BOUND_RST));
		program_register(REG_GOAL_PLACE, 24'd8388607);
		program_register(REG_GOAL_SPEED, 24'd1048576);
		program_register(REG_UNUSED, 24'hFFFFFF);
		send_item(CMD_RESTART, 24'd0, 21'(-520000));
		repeat (39) send_item(CMD_STEP, 24'd0, 21'(-450000));
		s_axis_tvalid <= 1'b0;
		wait_for_results();
		program_register(REG_EPISODE_LIMIT, 24'd10);
		repeat (5) send_item(CMD_STEP, 24'd0, 21'(-600000));
		s_axis_tvalid <= 1'b0;

		// random settings within the register ranges
		repeat (4) begin
			wait_for_results();
			program_register(REG_POWER_GAIN, 24'($urandom_range(0, 1048576)));
			program_register(REG_SPEED_LIMIT, 24'($urandom_range(0, 1048576)));
			program_register(REG_LEFT_BOUND, 24'(-int'($urandom_range(0, 8388608))));
			program_register(REG_RIGHT_BOUND, 24'($urandom_range(0, 8388607)));
			program_register(REG_GOAL_PLACE, 24'($urandom));
			program_register(REG_GOAL_SPEED, 24'(int'($urandom_range(0, 2097152)) - 1048576));
			program_register(REG_EPISODE_LIMIT, 24'($urandom_range(1, 300)));
			run_random(100);
		end

		// back to defaults
		wait_for_results();
		program_register(REG_POWER_GAIN, 24'(POWER_GAIN_RST));
		program_register(REG_SPEED_LIMIT, 24'(SPEED_LIMIT_RST));
		program_register(REG_LEFT_BOUND, LEFT_BOUND_RST);
		program_register(REG_RIGHT_BOUND, 24'(RIGHT_BOUND_RST));
		program_register(REG_GOAL_PLACE, GOAL_PLACE_RST);
		program_register(REG_GOAL_SPEED, 24'(GOAL_SPEED_RST));
		program_register(REG_EPISODE_LIMIT, 24'(EPISODE_LIMIT_RST));
		run_random(350);

		wait_for_results();
		repeat (8) @(posedge clk);
		if (car_sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* mountain_car_physics_step_top.f */
+incdir+hw/rtl
hw/rtl/mcp_pkg.sv
hw/rtl/mcp_cfg.sv
hw/rtl/mcp_in_stage.sv
hw/rtl/mcp_core.sv
hw/rtl/mountain_car_physics_step_top.sv
tb/mountain_car_physics_step_top_tb.sv
